### src/bagm_pkg.sv
// package for the box average glyph mapper: payload types, register codes, ramp tables
`default_nettype none

package bagm_pkg;

    // default limits handed to the top level parameters
    localparam int DEF_MAX_CELLS_ACROSS = 256;
    localparam int DEF_MAX_CELL_SIZE    = 64;
    localparam int DEF_MAX_IMAGE_WIDTH  = 4096;

    // fixed field and state widths
    localparam int PIX_W      = 8;
    localparam int GLYPH_W    = 7;
    localparam int SUM_W      = 20;
    localparam int ROW_W      = 13;
    localparam int MAX_CELLS_DOWN = 4096;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CS_REG_W   = 7;
    localparam int CA_REG_W   = 9;
    localparam int CD_REG_W   = 13;
    localparam int IW_REG_W   = 13;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_ACROSS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DOWN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd3;

    // register reset values
    localparam logic [CS_REG_W-1:0] RST_CELL_SIZE    = 7'd8;
    localparam logic [CA_REG_W-1:0] RST_CELLS_ACROSS = 9'd80;
    localparam logic [CD_REG_W-1:0] RST_CELLS_DOWN   = 13'd24;
    localparam logic [IW_REG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;

    // brightness ramp, first character is the darkest
    localparam int RAMP_LENGTH = 15;
    localparam int FULL_SCALE  = 255;
    localparam int IDX_W       = $clog2(RAMP_LENGTH);
    localparam int LVL_W       = (RAMP_LENGTH > 2) ? $clog2(RAMP_LENGTH - 1) : 1;

    typedef logic [RAMP_LENGTH-1:0][7:0] t_ramp_chars;
    typedef logic [RAMP_LENGTH-2:0][7:0] t_level_table;

    localparam t_ramp_chars RAMP_CHARS = " .-=+*padOAP#%@";

    // smallest average that reaches ramp index k+1: ceil(255*(k+1)/RAMP_LENGTH)
    function automatic t_level_table ramp_levels();
        t_level_table t;
        for (int k = 0; k < RAMP_LENGTH - 1; k++) begin
            t[k] = 8'((FULL_SCALE * (k + 1) + RAMP_LENGTH - 1) / RAMP_LENGTH);
        end
        return t;
    endfunction

    localparam t_level_table RAMP_LEVELS = ramp_levels();

    // payload of one input transaction
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_in_item;

    // payload of one output transaction
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               row_end;
    } t_out_item;

endpackage

`default_nettype wire

### src/box_average_glyph_mapper.sv
// top level: cell accumulation in a column sum memory, threshold compare and glyph output
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | i_in  (pixel, frame_start)
//  out     | output    | o_out_valid / i_out_ready| o_out (glyph, row_end)
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// one pixel per cycle while ready is high; the column sum memory is read at accept and written
// back from stage 1, with a one-deep forward for consecutive pixels of the same cell column.
// a completed cell passes stage 1 and stage 2 on its way to the output register.
// after reset and after each cell_size write, ready stays low while the ramp thresholds
// are rebuilt, one multiply a cycle.
// a stalled output holds back input only while completed cells wait in stage 2 and stage 1.
`default_nettype none

module box_average_glyph_mapper #(
    parameter int MAX_CELLS_ACROSS = bagm_pkg::DEF_MAX_CELLS_ACROSS,
    parameter int MAX_CELL_SIZE    = bagm_pkg::DEF_MAX_CELL_SIZE,
    parameter int MAX_IMAGE_WIDTH  = bagm_pkg::DEF_MAX_IMAGE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire bagm_pkg::t_in_item              i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output bagm_pkg::t_out_item                  o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [bagm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bagm_pkg::CFG_W-1:0]      i_cfg_data
);
    import bagm_pkg::*;

    localparam int CS_W   = $clog2(MAX_CELL_SIZE + 1);
    localparam int CA_W   = $clog2(MAX_CELLS_ACROSS + 1);
    localparam int SLOT_W = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
    localparam int PC_W   = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
    localparam int IW_W   = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int AREA_W = 2 * CS_W;
    localparam int THR_W  = AREA_W + 8;
    localparam int CMP_W  = THR_W + SUM_W;

    // configuration registers
    logic [CS_REG_W-1:0] r_cell_size;
    logic [CA_REG_W-1:0] r_cells_across;
    logic [CD_REG_W-1:0] r_cells_down;
    logic [IW_REG_W-1:0] r_image_width;

    // position counters
    logic [PC_W-1:0]  r_pixel_column, n_pixel_column;
    logic [CS_W-1:0]  r_column_in_cell, n_column_in_cell;
    logic [CA_W-1:0]  r_cell_column, n_cell_column;
    logic [CS_W-1:0]  r_line_in_cell, n_line_in_cell;
    logic [ROW_W-1:0] r_cell_row, n_cell_row;

    // counters as seen by the current pixel, after frame start
    logic [PC_W-1:0]  cur_pixel_column;
    logic [CS_W-1:0]  cur_column_in_cell;
    logic [CA_W-1:0]  cur_cell_column;
    logic [CS_W-1:0]  cur_line_in_cell;
    logic [ROW_W-1:0] cur_cell_row;

    // clamped configuration
    logic [CS_W-1:0]  cs_c, cs_m1;
    logic [CA_W-1:0]  ca_c, ca_m1;
    logic [ROW_W-1:0] cd_c;
    logic [IW_W-1:0]  iw_c;
    logic [PC_W-1:0]  iw_m1;

    // threshold sweep
    logic                            r_sweeping;
    logic [IDX_W-1:0]                r_sweep_cnt;
    logic [AREA_W-1:0]               r_area;
    logic [THR_W-1:0]                r_level [RAMP_LENGTH-1];
    logic [LVL_W-1:0]                level_sel;

    // stage 0 decode
    logic             accept;
    logic             in_grid;
    logic             cell_done;
    logic             last_across;
    logic [SLOT_W-1:0] slot;

    // stage 1: read data back, add, write
    logic [SUM_W-1:0]  mem [MAX_CELLS_ACROSS];
    logic              r_s1_valid;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [PIX_W-1:0]  r_s1_pixel;
    logic              r_s1_first;
    logic              r_s1_complete;
    logic              r_s1_row_end;
    logic [SUM_W-1:0]  r_rdata;
    logic              r_fwd_hit;
    logic [SUM_W-1:0]  r_fwd_data;
    logic [SUM_W-1:0]  s1_base;
    logic [SUM_W-1:0]  s1_sum;
    logic              s1_stall;

    // stage 2: threshold compare
    logic                   r_s2_valid;
    logic [SUM_W-1:0]       r_s2_sum;
    logic                   r_s2_row_end;
    logic                   s2_stall;
    logic [RAMP_LENGTH-2:0] over;
    logic [IDX_W-1:0]       ramp_idx;

    // output register
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size    <= RST_CELL_SIZE;
            r_cells_across <= RST_CELLS_ACROSS;
            r_cells_down   <= RST_CELLS_DOWN;
            r_image_width  <= RST_IMAGE_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CELL_SIZE:    r_cell_size    <= i_cfg_data[CS_REG_W-1:0];
                CFG_CELLS_ACROSS: r_cells_across <= i_cfg_data[CA_REG_W-1:0];
                CFG_CELLS_DOWN:   r_cells_down   <= i_cfg_data[CD_REG_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IW_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp registers to their legal range
    always_comb begin
        if (r_cell_size == '0) cs_c = CS_W'(1);
        else if (int'(r_cell_size) > MAX_CELL_SIZE) cs_c = CS_W'(MAX_CELL_SIZE);
        else cs_c = CS_W'(r_cell_size);

        if (r_cells_across == '0) ca_c = CA_W'(1);
        else if (int'(r_cells_across) > MAX_CELLS_ACROSS) ca_c = CA_W'(MAX_CELLS_ACROSS);
        else ca_c = CA_W'(r_cells_across);

        if (r_cells_down == '0) cd_c = ROW_W'(1);
        else if (int'(r_cells_down) > MAX_CELLS_DOWN) cd_c = ROW_W'(MAX_CELLS_DOWN);
        else cd_c = ROW_W'(r_cells_down);

        if (r_image_width == '0) iw_c = IW_W'(1);
        else if (int'(r_image_width) > MAX_IMAGE_WIDTH) iw_c = IW_W'(MAX_IMAGE_WIDTH);
        else iw_c = IW_W'(r_image_width);

        cs_m1 = cs_c - CS_W'(1);
        ca_m1 = ca_c - CA_W'(1);
        iw_m1 = PC_W'(iw_c - IW_W'(1));
    end

    // threshold sweep after reset or a cell size change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping  <= 1'b1;
            r_sweep_cnt <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_CELL_SIZE) begin
            r_sweeping  <= 1'b1;
            r_sweep_cnt <= '0;
        end else if (r_sweeping) begin
            if (r_sweep_cnt == IDX_W'(RAMP_LENGTH - 1)) r_sweeping <= 1'b0;
            else r_sweep_cnt <= r_sweep_cnt + IDX_W'(1);
        end
    end

    assign level_sel = LVL_W'(r_sweep_cnt - IDX_W'(1));

    // cell area and sum thresholds, one product a cycle
    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(cs_c) * AREA_W'(cs_c);
        if (r_sweeping && r_sweep_cnt != '0) begin
            r_level[level_sel] <= THR_W'(r_area) * THR_W'(RAMP_LEVELS[level_sel]);
        end
    end

    // stage 0: current position and what this pixel does
    always_comb begin
        if (i_in.frame_start) begin
            cur_pixel_column   = '0;
            cur_column_in_cell = '0;
            cur_cell_column    = '0;
            cur_line_in_cell   = '0;
            cur_cell_row       = '0;
        end else begin
            cur_pixel_column   = r_pixel_column;
            cur_column_in_cell = r_column_in_cell;
            cur_cell_column    = r_cell_column;
            cur_line_in_cell   = r_line_in_cell;
            cur_cell_row       = r_cell_row;
        end

        in_grid     = (cur_cell_row < cd_c) && (cur_cell_column < ca_c);
        cell_done   = (cur_column_in_cell >= cs_m1) && (cur_line_in_cell >= cs_m1);
        last_across = (cur_cell_column == ca_m1);
        slot        = SLOT_W'(cur_cell_column);

        n_pixel_column   = cur_pixel_column;
        n_column_in_cell = cur_column_in_cell;
        n_cell_column    = cur_cell_column;
        n_line_in_cell   = cur_line_in_cell;
        n_cell_row       = cur_cell_row;
        if (cur_pixel_column >= iw_m1) begin
            n_pixel_column   = '0;
            n_column_in_cell = '0;
            n_cell_column    = '0;
            if (cur_cell_row < cd_c) begin
                if (cur_line_in_cell >= cs_m1) begin
                    n_line_in_cell = '0;
                    n_cell_row     = cur_cell_row + ROW_W'(1);
                end else begin
                    n_line_in_cell = cur_line_in_cell + CS_W'(1);
                end
            end
        end else begin
            n_pixel_column = cur_pixel_column + PC_W'(1);
            if (cur_cell_column < ca_c) begin
                if (cur_column_in_cell >= cs_m1) begin
                    n_column_in_cell = '0;
                    n_cell_column    = cur_cell_column + CA_W'(1);
                end else begin
                    n_column_in_cell = cur_column_in_cell + CS_W'(1);
                end
            end
        end
    end

    // handshake and stall chain
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_stall   = r_s2_valid && !out_free;
    assign s1_stall   = r_s1_valid && r_s1_complete && s2_stall;
    assign o_in_ready = !r_sweeping && !s1_stall;
    assign accept     = i_in_valid && o_in_ready;

    // position counters advance on every input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_column   <= '0;
            r_column_in_cell <= '0;
            r_cell_column    <= '0;
            r_line_in_cell   <= '0;
            r_cell_row       <= '0;
        end else if (accept) begin
            r_pixel_column   <= n_pixel_column;
            r_column_in_cell <= n_column_in_cell;
            r_cell_column    <= n_cell_column;
            r_line_in_cell   <= n_line_in_cell;
            r_cell_row       <= n_cell_row;
        end
    end

    // stage 1 sum: first line of a cell overwrites, later lines add
    assign s1_base = r_fwd_hit ? r_fwd_data : r_rdata;
    assign s1_sum  = r_s1_first ? SUM_W'(r_s1_pixel)
                                : SUM_W'(s1_base + SUM_W'(r_s1_pixel));

    // column sum memory: read at accept, write back from stage 1
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && !s1_stall) mem[r_s1_slot] <= s1_sum;
        if (accept) r_rdata <= mem[slot];
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (!s1_stall) begin
            r_s1_valid <= accept && in_grid;
            r_fwd_hit  <= accept && in_grid && r_s1_valid && (r_s1_slot == slot);
        end
    end

    // stage 1 payload and forward data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_slot     <= slot;
            r_s1_pixel    <= i_in.pixel;
            r_s1_first    <= (cur_line_in_cell == '0);
            r_s1_complete <= cell_done;
            r_s1_row_end  <= last_across;
            r_fwd_data    <= s1_sum;
        end
    end

    // stage 2 holds a completed cell sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!s2_stall) begin
            r_s2_valid <= r_s1_valid && r_s1_complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s2_stall) begin
            r_s2_sum     <= s1_sum;
            r_s2_row_end <= r_s1_row_end;
        end
    end

    // ramp index: number of thresholds the sum reaches
    always_comb begin
        for (int k = 0; k < RAMP_LENGTH - 1; k++) begin
            over[k] = CMP_W'(r_s2_sum) >= CMP_W'(r_level[k]);
        end
        ramp_idx = IDX_W'($countones(over));
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_out.glyph   <= RAMP_CHARS[IDX_W'(RAMP_LENGTH - 1) - ramp_idx][GLYPH_W-1:0];
            r_out.row_end <= r_s2_row_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // forward only ever points at a live stage 1 item
    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forward hit without a stage 1 item");

    // a stalled stage 1 item keeps its slot and does not vanish
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_stall |=> r_s1_valid && $stable(r_s1_slot))
        else $error("stalled stage 1 item lost");

    // a completed cell blocked by the output stays in stage 2
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_out_valid && !i_out_ready |=> r_s2_valid && $stable(r_s2_sum))
        else $error("completed cell dropped under stall");

    // no pixel taken while thresholds are rebuilt
    a_sweep_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweeping |-> !o_in_ready)
        else $error("input taken during threshold sweep");

    // every glyph is a printable character
    a_glyph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.glyph >= 7'd32) && (o_out.glyph <= 7'd126))
        else $error("glyph out of printable range");

endmodule

`default_nettype wire
